// ----- design/assert_macros.svh -----
// Assertion helpers shared by the design files.
// Each macro is clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/gri_pkg.sv -----
package gri_pkg;

  // Field widths.
  localparam int unsigned ANGLE_BITS = 32;
  localparam int unsigned TIME_BITS  = 24;
  localparam int unsigned RATE_W     = 16;
  localparam int unsigned DBAND_W    = 15;
  localparam int unsigned GAIN_W     = 32;
  localparam int unsigned NUM_AXES   = 3;

  // Multiplier datapath widths.
  localparam int unsigned MAG_W      = RATE_W + 1;
  localparam int unsigned RT_W       = MAG_W + TIME_BITS;
  localparam int unsigned LO_W       = 32;
  localparam int unsigned HI_W       = RT_W - LO_W;
  localparam int unsigned PROD_W     = RT_W + GAIN_W;
  localparam int unsigned PROD_SHIFT = 64 - ANGLE_BITS;

  // Stream and configuration widths.
  localparam int unsigned IN_DATA_W  = ((NUM_AXES * RATE_W + TIME_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((NUM_AXES * ANGLE_BITS + 7) / 8) * 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = GAIN_W;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN     = CFG_IDX_W'(1);

  // Register reset values.
  localparam logic [DBAND_W-1:0] DBAND_RESET = DBAND_W'(28);
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(32'd3586866904);

  // Sequencing from the top level to each lane.
  typedef struct packed {
    logic start;   // item accepted: latch kept rate times time, keep new rate if above deadband
    logic finish;  // apply the increment to the angle
    logic zero;    // clear the angle when finishing
  } lane_ctrl_t;

endpackage

// ----- design/gri_lane.sv -----
`include "assert_macros.svh"

module gri_lane (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  gri_pkg::lane_ctrl_t                  ctrl_i,
  input  logic signed [gri_pkg::RATE_W-1:0]    raw_i,
  input  logic [gri_pkg::TIME_BITS-1:0]        elapsed_i,
  input  logic [gri_pkg::DBAND_W-1:0]          deadband_i,
  input  logic [gri_pkg::GAIN_W-1:0]           gain_i,
  output logic [gri_pkg::ANGLE_BITS-1:0]       angle_next_o
);
  import gri_pkg::*;

  logic [RATE_W-1:0]     kept_q, kept_d;
  logic [ANGLE_BITS-1:0] angle_q, angle_d;
  logic                  active_q, active_d;
  logic                  neg_q, neg_d;
  logic [RT_W-1:0]       rt_q, rt_d;
  logic [LO_W+GAIN_W-1:0] lprod_q;
  logic [HI_W+GAIN_W-1:0] hprod_q;
  logic [MAG_W-1:0]      raw_mag, kept_mag;
  logic [PROD_W-1:0]     prod_sum;
  logic [ANGLE_BITS-1:0] incr;

  // Magnitudes in one extra bit so the most negative rate is exact.
  assign raw_mag  = raw_i[RATE_W-1] ? (MAG_W'(0) - {raw_i[RATE_W-1], raw_i})
                                    : {1'b0, raw_i};
  assign kept_mag = kept_q[RATE_W-1] ? (MAG_W'(0) - {kept_q[RATE_W-1], kept_q})
                                     : {1'b0, kept_q};

  // First stage: deadband test and kept rate times elapsed time.
  always_comb begin
    active_d = active_q;
    neg_d    = neg_q;
    kept_d   = kept_q;
    rt_d     = rt_q;
    if (ctrl_i.start) begin
      active_d = raw_mag > MAG_W'(deadband_i);
      neg_d    = kept_q[RATE_W-1];
      rt_d     = RT_W'(kept_mag) * RT_W'(elapsed_i);
      if (active_d) begin
        kept_d = raw_i;
      end
    end
  end

  // Last stage: recombine partial products, scale and accumulate.
  assign prod_sum = {hprod_q, {LO_W{1'b0}}} + PROD_W'(lprod_q);
  assign incr     = prod_sum[PROD_SHIFT +: ANGLE_BITS];

  always_comb begin
    angle_d = angle_q;
    if (active_q) begin
      angle_d = neg_q ? (angle_q - incr) : (angle_q + incr);
    end
    if (ctrl_i.zero) begin
      angle_d = '0;
    end
  end

  assign angle_next_o = angle_d;

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_q   <= '0;
      angle_q  <= '0;
      active_q <= 1'b0;
      neg_q    <= 1'b0;
    end else begin
      kept_q   <= kept_d;
      active_q <= active_d;
      neg_q    <= neg_d;
      if (ctrl_i.finish) begin
        angle_q <= angle_d;
      end
    end
  end

  // Datapath registers; the partial products split the gain multiply in two.
  always_ff @(posedge clk_i) begin
    rt_q    <= rt_d;
    lprod_q <= (LO_W+GAIN_W)'(rt_q[LO_W-1:0]) * (LO_W+GAIN_W)'(gain_i);
    hprod_q <= (HI_W+GAIN_W)'(rt_q[RT_W-1:LO_W]) * (HI_W+GAIN_W)'(gain_i);
  end

  `ASSERT_NEXT(a_zero_clears, ctrl_i.finish && ctrl_i.zero, angle_q == '0)
  `ASSERT_NEXT(a_quiet_holds, ctrl_i.start && !active_d, kept_q == $past(kept_q))
  `ASSERT_NEXT(a_active_keeps, ctrl_i.start && active_d, kept_q == $past(raw_i))

endmodule

// ----- design/gyro_rate_integrator_core.sv -----
// Three-axis gyro angle integrator. Each input item carries three signed raw
// rates, the microseconds since the previous sample and a zero request; each
// item yields exactly one result with the three angles as unsigned fractions
// of a full turn. Axes whose raw rate magnitude exceeds the deadband advance by
// the previously kept rate times elapsed time times the Q0.32 gain, and keep the
// new rate. Each axis has its own lane, in which an item passes through two
// pipelined multiply stages, rate times time and then the split gain multiply,
// and then the accumulate; a new item is taken only in the idle state, after the
// previous one has finished. The finished result sits in an output register, so
// the next item is accepted while it waits; a stalled output holds the last stage.
// Configuration writes are applied at once and must only be made while idle.
`include "assert_macros.svh"

module gyro_rate_integrator_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input items.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // Fields from bit 0 up: raw_x, raw_y, raw_z, elapsed_us.
  input  logic [gri_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // Fields from bit 0 up: zero_request.
  input  logic                              s_axis_tuser,
  // Result items.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // Fields from bit 0 up: angle_x, angle_y, angle_z.
  output logic [gri_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // Configuration writes.
  input  logic                              cfg_we_i,
  input  logic [gri_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [gri_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import gri_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC
  } state_e;

  state_e                 state_q, state_d;
  logic                   m_tvalid_q, m_tvalid_d;
  logic [OUT_DATA_W-1:0]  m_tdata_q, m_tdata_d;
  logic                   zero_q, zero_d;
  logic [DBAND_W-1:0]     deadband_q;
  logic [GAIN_W-1:0]      gain_q;
  logic                   accept, finish;
  lane_ctrl_t             lane_ctrl;
  logic [NUM_AXES*ANGLE_BITS-1:0] angles;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign finish        = (state_q == ST_ACC) && (!m_tvalid_q || m_axis_tready);

  assign lane_ctrl.start  = accept;
  assign lane_ctrl.finish = finish;
  assign lane_ctrl.zero   = zero_q;

  // One lane per axis.
  for (genvar ax = 0; ax < NUM_AXES; ax++) begin : g_lane
    gri_lane u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (lane_ctrl),
      .raw_i        (s_axis_tdata[ax*RATE_W +: RATE_W]),
      .elapsed_i    (s_axis_tdata[NUM_AXES*RATE_W +: TIME_BITS]),
      .deadband_i   (deadband_q),
      .gain_i       (gain_q),
      .angle_next_o (angles[ax*ANGLE_BITS +: ANGLE_BITS])
    );
  end

  // Sequencer and merge of the lane angles into the output register.
  always_comb begin
    state_d    = state_q;
    zero_d     = zero_q;
    m_tdata_d  = m_tdata_q;
    m_tvalid_d = m_tvalid_q && !m_axis_tready;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_MUL;
          zero_d  = s_axis_tuser;
        end
      end
      ST_MUL: begin
        state_d = ST_ACC;
      end
      ST_ACC: begin
        if (finish) begin
          state_d    = ST_IDLE;
          m_tvalid_d = 1'b1;
          m_tdata_d  = OUT_DATA_W'(angles);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      m_tvalid_q <= 1'b0;
      m_tdata_q  <= '0;
      zero_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      m_tvalid_q <= m_tvalid_d;
      m_tdata_q  <= m_tdata_d;
      zero_q     <= zero_d;
    end
  end

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q <= DBAND_RESET;
      gain_q     <= GAIN_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_DEADBAND) begin
        deadband_q <= cfg_data_i[DBAND_W-1:0];
      end
      if (cfg_index_i == REG_GAIN) begin
        gain_q <= cfg_data_i[GAIN_W-1:0];
      end
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

  `ASSERT_NEXT(a_finish_shows, finish, m_axis_tvalid)
  `ASSERT_NEXT(a_accept_runs, accept, state_q == ST_MUL)
  `ASSERT_IMPL(a_stall_no_finish, (state_q == ST_ACC) && m_tvalid_q && !m_axis_tready, !finish)

endmodule
